// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_EQ  = 4'd4,
    OP_NE  = 4'd5,
    OP_GT  = 4'd6,
    OP_LT  = 4'd7,
    OP_GE  = 4'd8,
    OP_LE  = 4'd9
  } op_e;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ZERODEN = 2'd1;
  localparam logic [1:0] STATUS_OVF     = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic mul_a;     // first product pair
    logic mul_b;     // second product pair, combine
    logic gcd_init;  // prepare gcd operands
    logic gcd_step;  // one binary gcd step
    logic div_init;  // start both divisions
    logic div_step;  // one restoring division bit
    logic finish;    // form result fields
  } rau_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trivial;   // zero numerator, zero denominator or non-arithmetic op
    logic gcd_done;
    logic div_done;
  } rau_sts_t;

endpackage

// ===== hw/rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: products, gcd loop, division loop, output handshake
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  rau_sts_t sts_i,
  output rau_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MULA  = 8'b0000_0010,
    S_MULB  = 8'b0000_0100,
    S_GINIT = 8'b0000_1000,
    S_GCD   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MULA;
        end
      end
      S_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d     = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = S_GINIT;
      end
      S_GINIT: begin
        if (sts_i.trivial) begin
          state_d = S_FIN;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

// ===== hw/rtl/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// datapath: cross products, binary gcd, two restoring divisions, result
// ----------------------------------------------------------------------------
module rau_dp
  import rau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rau_cmd_t           cmd_i,
  output rau_sts_t           sts_o,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  output logic signed [31:0] res_num_o,
  output logic signed [31:0] res_den_o,
  output logic               truth_o,
  output logic [1:0]         status_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned PW = 2 * VALUE_WIDTH;     // product magnitude width
  localparam int unsigned MW = PW + 1;              // sum magnitude width
  localparam int unsigned CW = $clog2(MW + 1);

  logic [3:0]          op_q;
  logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0] p0_q, p1_q;  // first pair of products
  logic        nneg_q, dneg_q;
  logic [MW-1:0] nmag_q, dmag_q;
  logic [MW-1:0] gx_q, gy_q;
  logic [CW-1:0] shift_q;
  logic [MW-1:0] g_q;
  logic [MW-1:0] qn_q, qd_q, rn_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          t_q;

  logic is_arith, is_cmp;
  assign is_arith = (op_q <= 4'(OP_DIV));
  assign is_cmp   = (op_q >= 4'(OP_EQ)) && (op_q <= 4'(OP_LE));

  // operand capture, truncated to the value width
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      an_q <= a_num_i[W-1:0];
      ad_q <= a_den_i[W-1:0];
      bn_q <= b_num_i[W-1:0];
      bd_q <= b_den_i[W-1:0];
    end
  end

  // product selection: one pair of multipliers reused for both product pairs
  logic signed [W-1:0] ma0, mb0, ma1, mb1;
  logic signed [PW-1:0] pr0, pr1;
  always_comb begin
    if (cmd_i.mul_a) begin
      // numerator pair (or comparison cross products)
      ma0 = an_q;
      mb0 = (op_q == 4'(OP_MUL)) ? bn_q : bd_q;
      ma1 = bn_q;
      mb1 = ad_q;
    end else begin
      ma0 = ad_q;
      mb0 = (op_q == 4'(OP_DIV)) ? bn_q : bd_q;
      ma1 = ad_q;
      mb1 = bd_q;
    end
  end
  assign pr0 = ma0 * mb0;
  assign pr1 = ma1 * mb1;

  logic signed [PW:0] s0, s1, nsum;
  assign s0   = {p0_q[PW-1], p0_q};
  assign s1   = {p1_q[PW-1], p1_q};
  assign nsum = (op_q == 4'(OP_ADD)) ? s0 + s1 :
                (op_q == 4'(OP_SUB)) ? s0 - s1 : s0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      p0_q <= pr0;
      p1_q <= pr1;
    end
    if (cmd_i.mul_b) begin
      nneg_q <= nsum[PW];
      nmag_q <= nsum[PW] ? MW'(-nsum) : MW'(nsum);
      dneg_q <= pr0[PW-1];
      dmag_q <= pr0[PW-1] ? MW'(-{pr0[PW-1], pr0}) : MW'({1'b0, pr0});
      // comparison outcome: ordering from the first pair, equality from the operands
      case (op_q)
        4'(OP_EQ): t_q <= (an_q == bn_q) && (ad_q == bd_q);
        4'(OP_NE): t_q <= !((an_q == bn_q) && (ad_q == bd_q));
        4'(OP_GT): t_q <= p0_q > p1_q;
        4'(OP_LT): t_q <= p0_q < p1_q;
        4'(OP_GE): t_q <= p0_q >= p1_q;
        4'(OP_LE): t_q <= p0_q <= p1_q;
        default:   t_q <= 1'b0;
      endcase
    end
  end

  // binary gcd: common twos stripped first, then one shift or subtract per step
  logic gcd_done;
  logic [MW-1:0] ys, gmin, gdif;
  logic both_even;
  assign both_even = !gx_q[0] && !gy_q[0];
  assign ys   = gy_q;
  assign gmin = (gx_q > gy_q) ? gy_q : gx_q;
  assign gdif = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;
  assign gcd_done = (gy_q == '0) && gx_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      gx_q    <= nmag_q;
      gy_q    <= dmag_q;
      shift_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (both_even) begin
        gx_q    <= gx_q >> 1;
        gy_q    <= gy_q >> 1;
        shift_q <= shift_q + 1'b1;
      end else if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (ys != '0 && !ys[0]) begin
        gy_q <= gy_q >> 1;
      end else begin
        gx_q <= gmin;
        gy_q <= gdif;
      end
    end
  end

  // two restoring divisions by the gcd, one quotient bit per cycle
  logic [MW:0] trn, trd;
  assign trn = {rn_q, qn_q[MW-1]} - {1'b0, g_q};
  assign trd = {rd_q, qd_q[MW-1]} - {1'b0, g_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      g_q   <= gx_q << shift_q;
      qn_q  <= nmag_q;
      qd_q  <= dmag_q;
      rn_q  <= '0;
      rd_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (!trn[MW]) begin
        rn_q <= trn[MW-1:0];
        qn_q <= {qn_q[MW-2:0], 1'b1};
      end else begin
        rn_q <= {rn_q[MW-2:0], qn_q[MW-1]};
        qn_q <= {qn_q[MW-2:0], 1'b0};
      end
      if (!trd[MW]) begin
        rd_q <= trd[MW-1:0];
        qd_q <= {qd_q[MW-2:0], 1'b1};
      end else begin
        rd_q <= {rd_q[MW-2:0], qd_q[MW-1]};
        qd_q <= {qd_q[MW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= CW'(MW);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  logic nz, dz;
  assign nz = (nmag_q == '0);
  assign dz = (dmag_q == '0);

  assign sts_o.trivial  = !is_arith || nz || dz;
  assign sts_o.gcd_done = gcd_done;
  assign sts_o.div_done = (cnt_q == '0);

  // signed output bits, sign-extended from the value width
  function automatic logic [31:0] out_bits(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] b;
    logic [W-1:0]  lo;
    b  = neg ? -mag : mag;
    lo = b[W-1:0];
    return 32'(signed'(lo));
  endfunction

  function automatic logic fits(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] lim;
    lim = MW'(1) << (W - 1);
    return neg ? (mag <= lim) : (mag < lim);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_num_o <= '0;
      res_den_o <= '0;
      truth_o   <= 1'b0;
      status_o  <= STATUS_OK;
      if (is_arith) begin
        if (nz) begin
          res_den_o <= 32'sd1;
        end else if (dz) begin
          res_num_o <= out_bits(nneg_q, nmag_q);
          status_o  <= STATUS_ZERODEN;
        end else begin
          res_num_o <= out_bits(nneg_q, qn_q);
          res_den_o <= out_bits(dneg_q, qd_q);
          status_o  <= (fits(nneg_q, qn_q) && fits(dneg_q, qd_q)) ? STATUS_OK
                                                                  : STATUS_OVF;
        end
      end else if (is_cmp) begin
        truth_o <= t_q;
      end
    end
  end

endmodule

// ===== hw/rtl/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit
// exact add, sub, mul, div and compare of two fractions with gcd reduction
// ----------------------------------------------------------------------------
// One transaction at a time. Comparisons and trivial results skip the loops;
// arithmetic adds a binary gcd over the product magnitudes (one shift or
// subtract per step) and two parallel restoring divisions by the gcd.
// The result waits in an output register until taken; the next input is
// taken after that.
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] res_num_o,
  output logic signed [31:0] res_den_o,
  output logic               truth_o,
  output logic [1:0]         status_o
);

  rau_cmd_t cmd;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rau_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .op_i      (op_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .truth_o   (truth_o),
    .status_o  (status_o)
  );

endmodule
